// ----- rtl/swm_pkg.sv -----
package swm_pkg;

   // Default geometry of the window store
   localparam int DEF_MAX_WINDOW   = 1024;
   localparam int DEF_SAMPLE_WIDTH = 32;

   // Width of the window length register
   localparam int CFG_WIDTH = 11;

   // Sequencer states, one-hot
   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_FRONT = 5'b00010,
      ST_BACK  = 5'b00100,
      ST_PUSH  = 5'b01000,
      ST_DONE  = 5'b10000
   } swm_state_type;

endpackage

// ----- rtl/swm_ram.sv -----
module swm_ram #(
   parameter int DEPTH = swm_pkg::DEF_MAX_WINDOW,
   parameter int WIDTH = swm_pkg::DEF_SAMPLE_WIDTH
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   import swm_pkg::*;

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read, hold data between reads
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/sliding_window_minimum_core.sv -----
// Sliding window minimum over a stream of signed samples.
// Input channel req_*: one sample per item, with req_new_sequence set to
// start a fresh window (the window and counters clear before that sample).
// Result channel rsp_*: one minimum per item once window_length samples of
// the current sequence have been seen; earlier items give no result.
// csr_window_length is written whenever csr_write_enable is high outside
// reset; 0 acts as 1 and values above MAX_WINDOW act as MAX_WINDOW.
// Sequence per item: after acceptance the aged front entries are dropped,
// then the back entries not below the new sample are dropped, then the
// sample is pushed and the minimum is read and loaded into the output
// register. The next item is accepted only once the sequencer is back in
// idle, so items do not overlap; every candidate dropped from either end of
// the list adds a further read of the memory. Each sample is stored once and
// dropped at most once. The single registered read port of the candidate
// memory paces the front and back checks.
// req_ready is high only between items. A finished result waits in the output
// register; the next item is accepted meanwhile, and its result waits in the
// last stage until rsp_ready frees the register.
// Reset clears all counters and sets window_length to 1. The candidate memory
// needs no clearing pass: data read from an entry not yet written is never used.
module sliding_window_minimum_core #(
   parameter int MAX_WINDOW   = swm_pkg::DEF_MAX_WINDOW,
   parameter int SAMPLE_WIDTH = swm_pkg::DEF_SAMPLE_WIDTH
) (
   input  logic                            clock,
   input  logic                            reset,
   // configuration
   input  logic                            csr_write_enable,
   input  logic [swm_pkg::CFG_WIDTH-1:0]   csr_window_length,
   // input channel
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic signed [SAMPLE_WIDTH-1:0]  req_sample,
   input  logic                            req_new_sequence,
   // result channel
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic signed [SAMPLE_WIDTH-1:0]  rsp_window_minimum
);
   import swm_pkg::*;

   localparam int IDX_W   = $clog2(MAX_WINDOW);
   localparam int CNT_W   = $clog2(MAX_WINDOW + 1);
   localparam int POS_W   = $clog2(2 * MAX_WINDOW);
   localparam int ENTRY_W = SAMPLE_WIDTH + POS_W;

   // Ring index helpers
   function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] i);
      return (i == IDX_W'(MAX_WINDOW - 1)) ? '0 : i + IDX_W'(1);
   endfunction

   function automatic logic [IDX_W-1:0] ring_prev(input logic [IDX_W-1:0] i);
      return (i == '0) ? IDX_W'(MAX_WINDOW - 1) : i - IDX_W'(1);
   endfunction

   swm_state_type                   state_ff, state_in;
   logic [IDX_W-1:0]                head_ff, head_in;
   logic [IDX_W-1:0]                tail_ff, tail_in;
   logic [CNT_W-1:0]                count_ff, count_in;
   logic [CNT_W-1:0]                fill_ff, fill_in;
   logic [POS_W-1:0]                pos_ff, pos_in;
   logic [CNT_W-1:0]                win_ff, win_in;
   logic signed [SAMPLE_WIDTH-1:0]  sample_ff, sample_in;
   logic                            empty_push_ff, empty_push_in;
   logic [CFG_WIDTH-1:0]            window_length_ff;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_WIDTH-1:0]  rsp_min_ff, rsp_min_in;

   logic                            req_take;
   logic                            out_free;
   logic                            result_due;
   logic                            rsp_load;
   logic [31:0]                     window_ext;
   logic [CNT_W-1:0]                win_clamped;

   logic                            ram_wr_en;
   logic [IDX_W-1:0]                ram_wr_addr;
   logic [ENTRY_W-1:0]              ram_wr_data;
   logic                            ram_rd_en;
   logic [IDX_W-1:0]                ram_rd_addr;
   logic [ENTRY_W-1:0]              ram_rd_data;

   logic [POS_W-1:0]                rd_pos;
   logic signed [SAMPLE_WIDTH-1:0]  rd_value;
   logic [POS_W:0]                  age;
   logic                            aged_out;
   logic [IDX_W-1:0]                push_head;
   logic [CNT_W-1:0]                push_count;

   // Candidate memory: value and stream position per entry
   swm_ram #(
      .DEPTH (MAX_WINDOW),
      .WIDTH (ENTRY_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign rd_pos   = ram_rd_data[POS_W-1:0];
   assign rd_value = $signed(ram_rd_data[POS_W +: SAMPLE_WIDTH]);

   // Age of the entry just read, modulo twice the window depth
   always_comb begin
      if ({1'b0, pos_ff} >= {1'b0, rd_pos}) begin
         age = {1'b0, pos_ff} - {1'b0, rd_pos};
      end else begin
         age = {1'b0, pos_ff} + (POS_W+1)'(2 * MAX_WINDOW) - {1'b0, rd_pos};
      end
   end
   assign aged_out = 32'(age) >= 32'(win_ff);

   // Clamp the configured window to 1..MAX_WINDOW
   assign window_ext = 32'(window_length_ff);
   always_comb begin
      if (window_ext == 32'd0) begin
         win_clamped = CNT_W'(1);
      end else if (window_ext > 32'(MAX_WINDOW)) begin
         win_clamped = CNT_W'(MAX_WINDOW);
      end else begin
         win_clamped = CNT_W'(window_ext);
      end
   end

   assign req_ready  = (state_ff == ST_IDLE);
   assign req_take   = req_valid && req_ready;
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign result_due = 32'(fill_ff) >= 32'(win_ff);

   // Drop one front entry if the store is full before the push
   always_comb begin
      if (32'(count_ff) >= 32'(MAX_WINDOW)) begin
         push_head  = ring_next(head_ff);
         push_count = count_ff - CNT_W'(1);
      end else begin
         push_head  = head_ff;
         push_count = count_ff;
      end
   end

   // Sequencer: front drops, back drops, push, report
   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      count_in      = count_ff;
      fill_in       = fill_ff;
      pos_in        = pos_ff;
      win_in        = win_ff;
      sample_in     = sample_ff;
      empty_push_in = empty_push_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = tail_ff;
      ram_wr_data   = {sample_ff, pos_ff};
      ram_rd_en     = 1'b0;
      ram_rd_addr   = head_ff;
      rsp_load      = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               sample_in   = req_sample;
               win_in      = win_clamped;
               ram_rd_en   = 1'b1;
               ram_rd_addr = head_ff;
               if (req_new_sequence) begin
                  head_in  = '0;
                  tail_in  = '0;
                  count_in = '0;
                  fill_in  = '0;
                  pos_in   = '0;
               end
               state_in = ST_FRONT;
            end
         end
         ST_FRONT: begin
            if (count_ff != '0 && aged_out) begin
               // drop the aged front entry, fetch the next one
               head_in     = ring_next(head_ff);
               count_in    = count_ff - CNT_W'(1);
               ram_rd_en   = 1'b1;
               ram_rd_addr = ring_next(head_ff);
            end else if (count_ff != '0) begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = ring_prev(tail_ff);
               state_in    = ST_BACK;
            end else begin
               state_in = ST_PUSH;
            end
         end
         ST_BACK: begin
            if (count_ff != '0 && rd_value >= sample_ff) begin
               // drop the back entry, newer equal sample wins
               tail_in     = ring_prev(tail_ff);
               count_in    = count_ff - CNT_W'(1);
               ram_rd_en   = 1'b1;
               ram_rd_addr = ring_prev(ring_prev(tail_ff));
            end else begin
               state_in = ST_PUSH;
            end
         end
         ST_PUSH: begin
            ram_wr_en     = 1'b1;
            head_in       = push_head;
            tail_in       = ring_next(tail_ff);
            count_in      = push_count + CNT_W'(1);
            pos_in        = (pos_ff == POS_W'(2 * MAX_WINDOW - 1)) ? '0 : pos_ff + POS_W'(1);
            fill_in       = (32'(fill_ff) < 32'(MAX_WINDOW)) ? fill_ff + CNT_W'(1) : fill_ff;
            empty_push_in = (count_ff == '0);
            ram_rd_en     = 1'b1;
            ram_rd_addr   = push_head;
            state_in      = ST_DONE;
         end
         ST_DONE: begin
            if (!result_due) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Output register
   assign rsp_min_in = empty_push_ff ? sample_ff : rd_value;
   always_comb begin
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         head_ff          <= '0;
         tail_ff          <= '0;
         count_ff         <= '0;
         fill_ff          <= '0;
         pos_ff           <= '0;
         window_length_ff <= CFG_WIDTH'(1);
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         fill_ff      <= fill_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            window_length_ff <= csr_window_length;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      win_ff        <= win_in;
      sample_ff     <= sample_in;
      empty_push_ff <= empty_push_in;
      if (rsp_load) begin
         rsp_min_ff <= rsp_min_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_window_minimum = rsp_min_ff;

   // Candidate count never exceeds the store
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= 32'(MAX_WINDOW))
      else $error("candidate count above store depth");

   // Ring pointers agree with the count
   a_ring_consistent: assert property (@(posedge clock) disable iff (reset)
      (32'(tail_ff) == 32'(head_ff) + 32'(count_ff)) ||
      (32'(tail_ff) + 32'(MAX_WINDOW) == 32'(head_ff) + 32'(count_ff)))
      else $error("ring pointers and count disagree");

   // New sequence empties the window
   a_new_sequence_clears: assert property (@(posedge clock) disable iff (reset)
      req_take && req_new_sequence |=> count_ff == '0 && fill_ff == '0)
      else $error("new sequence did not clear the window");

   // A due result with a free output register is presented next cycle
   a_result_loaded: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DONE && result_due && out_free |=> rsp_valid_ff && state_ff == ST_IDLE)
      else $error("due result not loaded");

   // Fill count saturates at the store depth
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      32'(fill_ff) <= 32'(MAX_WINDOW))
      else $error("fill count above store depth");

endmodule
